// ===== src/ifta_pkg.sv =====
// Shared constants and types for the three-axis IIR filter.
package ifta_pkg;

	// Default sizing handed to the top level
	localparam int DEF_TAPS           = 3;
	localparam int DEF_LANES          = 3;
	localparam int DEF_SAMPLE_BITS    = 16;
	localparam int DEF_COEF_FRAC_BITS = 20;

	// Fixed coefficient format and register map
	localparam int COEF_BITS    = 24;
	localparam int CFG_IDX_BITS = 3;
	localparam int NUM_AXES     = 3;

	localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = 24'sd1048576;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} coef_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
	} coef_set_t;

	// Per-transaction control broadcast to the lanes
	typedef struct packed {
		logic accept;	// new sample enters stage 1
		logic load;	// stage 1 result moves into the output register
		logic warm;	// sample belongs to the warm-up window
	} lane_ctl_t;

endpackage

// ===== src/ifta_intf.sv =====
// Channel interfaces: sample input, filtered result output, coefficient writes.
interface ifta_sample_if #(
	parameter int SAMPLE_BITS = ifta_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_x;
	logic signed [SAMPLE_BITS-1:0] sample_y;
	logic signed [SAMPLE_BITS-1:0] sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface ifta_result_if #(
	parameter int SAMPLE_BITS = ifta_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered_x;
	logic signed [SAMPLE_BITS-1:0] filtered_y;
	logic signed [SAMPLE_BITS-1:0] filtered_z;

	modport source (output valid, output filtered_x, output filtered_y,
		output filtered_z, input ready);
	modport sink (input valid, input filtered_x, input filtered_y, input filtered_z,
		output ready);
endinterface

interface ifta_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ifta_pkg::CFG_IDX_BITS-1:0]    index;
	logic [ifta_pkg::COEF_BITS-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ifta_coef_regs.sv =====
// Coefficient register bank written through the configuration channel.
module ifta_coef_regs (
	input  logic                clk,
	input  logic                arst_n,
	ifta_cfg_if.sink            cfg,
	output ifta_pkg::coef_set_t coef
);
	import ifta_pkg::*;

	coef_set_t coef_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_B0_RESET;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg.valid) begin
			unique case (coef_idx_t'(cfg.index))
				REG_B0: coef_q.b0 <= cfg.data;
				REG_B1: coef_q.b1 <= cfg.data;
				REG_B2: coef_q.b2 <= cfg.data;
				REG_A1: coef_q.a1 <= cfg.data;
				REG_A2: coef_q.a2 <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/ifta_lane.sv =====
// One axis of the biquad: histories, feedforward stage and feedback/rounding stage.
module ifta_lane #(
	parameter int TAPS           = ifta_pkg::DEF_TAPS,
	parameter int SAMPLE_BITS    = ifta_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = ifta_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                          clk,
	input  ifta_pkg::lane_ctl_t           ctl,
	input  ifta_pkg::coef_set_t           coef,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import ifta_pkg::*;

	localparam int  PROD_W = SAMPLE_BITS + COEF_BITS;
	localparam int  ACC_W  = PROD_W + 3;
	localparam bit  USE_K2 = (TAPS >= 3);
	localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	// Histories: last two inputs and last two outputs
	logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
	// Stage 1 payload
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          warm_s1;
	logic signed [ACC_W-1:0]       ff_s1;

	logic signed [COEF_BITS-1:0] b2_w, a2_w;
	logic signed [PROD_W-1:0]    p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]     ff_next, acc, shifted;
	logic                        fits;

	// Second-tap weights drop out for a two-tap filter
	assign b2_w = USE_K2 ? coef.b2 : '0;
	assign a2_w = USE_K2 ? coef.a2 : '0;

	// Stage 1: feedforward products and sum
	assign p_b0    = PROD_W'(sample) * PROD_W'(coef.b0);
	assign p_b1    = PROD_W'(x1_q) * PROD_W'(coef.b1);
	assign p_b2    = PROD_W'(x2_q) * PROD_W'(b2_w);
	assign ff_next = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			x2_q    <= x1_q;
			x1_q    <= sample;
			x_s1    <= sample;
			warm_s1 <= ctl.warm;
			ff_s1   <= ff_next;
		end
	end

	// Stage 2: feedback terms, rounding and range check
	assign p_a1    = PROD_W'(y1_q) * PROD_W'(coef.a1);
	assign p_a2    = PROD_W'(y2_q) * PROD_W'(a2_w);
	assign acc     = ff_s1 - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_C;
	assign shifted = acc >>> COEF_FRAC_BITS;
	assign fits    = (&shifted[ACC_W-1:SAMPLE_BITS-1]) | ~(|shifted[ACC_W-1:SAMPLE_BITS-1]);
	assign y       = (warm_s1 || !fits) ? x_s1 : shifted[SAMPLE_BITS-1:0];

	// Output history follows what is actually delivered
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			y2_q <= y1_q;
			y1_q <= y;
		end
	end

endmodule

// ===== src/ifta_merge.sv =====
// Output register gathering the lane results into one result transaction.
module ifta_merge #(
	parameter int SAMPLE_BITS = ifta_pkg::DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [SAMPLE_BITS-1:0] lane_y [ifta_pkg::NUM_AXES],
	output logic                          free,
	ifta_result_if.source                 res
);
	import ifta_pkg::*;

	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] fx_s2, fy_s2, fz_s2;

	// Register is free when empty or being drained this cycle
	assign free = !valid_s2 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fx_s2 <= lane_y[0];
			fy_s2 <= lane_y[1];
			fz_s2 <= lane_y[2];
		end
	end

	assign res.valid      = valid_s2;
	assign res.filtered_x = fx_s2;
	assign res.filtered_y = fy_s2;
	assign res.filtered_z = fz_s2;

endmodule

// ===== src/iir_filter_three_axis_core.sv =====
// Top level of the three-axis direct-form-I IIR filter.
// Takes x/y/z sample transactions and returns one filtered x/y/z result per
// sample via the stage 1 and output registers. Each axis has its own lane; the
// first TAPS samples after reset pass through unchanged to fill the histories,
// after which each output is b0*x[n] + b1*x[n-1] + b2*x[n-2] - a1*y[n-1] -
// a2*y[n-2] with Q3.20 weights, rounded to nearest (ties upward); a result that
// does not fit the sample width is replaced by the raw sample. Throughput is one
// transaction per cycle unless the output stalls, set by the second stage, where
// the a1 multiply on the previous output closes the feedback loop. Axes at LANES
// and above read as zero. The user must write coefficients through the
// configuration channel only while idle; the block does not enforce it.
module iir_filter_three_axis_core #(
	parameter int TAPS           = ifta_pkg::DEF_TAPS,
	parameter int LANES          = ifta_pkg::DEF_LANES,
	parameter int SAMPLE_BITS    = ifta_pkg::DEF_SAMPLE_BITS,
	parameter int COEF_FRAC_BITS = ifta_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	ifta_cfg_if.sink      cfg,
	ifta_sample_if.sink   sample_in,
	ifta_result_if.source filt_out
);
	import ifta_pkg::*;

	localparam int CNT_W = $clog2(TAPS + 1);

	coef_set_t                     coef;
	lane_ctl_t                     ctl;
	logic                          valid_s1_q;
	logic [CNT_W-1:0]              warm_cnt_q;
	logic                          free;
	logic signed [SAMPLE_BITS-1:0] samp   [NUM_AXES];
	logic signed [SAMPLE_BITS-1:0] lane_y [NUM_AXES];

	// Coefficient registers
	ifta_coef_regs u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	// Pipeline handshake
	assign ctl.load        = valid_s1_q && free;
	assign sample_in.ready = !valid_s1_q || ctl.load;
	assign ctl.accept      = sample_in.valid && sample_in.ready;
	assign ctl.warm        = (warm_cnt_q != CNT_W'(TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (ctl.accept) begin
			valid_s1_q <= 1'b1;
		end else if (ctl.load) begin
			valid_s1_q <= 1'b0;
		end
	end

	// Warm-up counter, saturates at TAPS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= '0;
		end else if (ctl.accept && ctl.warm) begin
			warm_cnt_q <= warm_cnt_q + CNT_W'(1);
		end
	end

	assign samp[0] = sample_in.sample_x;
	assign samp[1] = sample_in.sample_y;
	assign samp[2] = sample_in.sample_z;

	// Axis lanes
	for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
		if (l < LANES) begin : g_on
			ifta_lane #(
				.TAPS           (TAPS),
				.SAMPLE_BITS    (SAMPLE_BITS),
				.COEF_FRAC_BITS (COEF_FRAC_BITS)
			) u_lane (
				.clk    (clk),
				.ctl    (ctl),
				.coef   (coef),
				.sample (samp[l]),
				.y      (lane_y[l])
			);
		end else begin : g_off
			assign lane_y[l] = '0;
		end
	end

	// Result register
	ifta_merge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.load),
		.lane_y (lane_y),
		.free   (free),
		.res    (filt_out)
	);

endmodule
